// ===== sv/etsc_pkg.sv =====
// ---------------------------------------------------------------------------
// Expression token scanner package
// Shared word types, token kind codes and character and keyword helper functions.
// ---------------------------------------------------------------------------
package etsc_pkg;

	localparam int POS_BITS = 16;
	localparam int VAL_BITS = 32;
	localparam int KIND_BITS = 6;
	localparam int KW_COUNT = 23;
	localparam int KW_MAX_LEN = 21;
	localparam int KW_IDX_BITS = $clog2(KW_MAX_LEN);

	localparam logic [KIND_BITS-1:0] K_END        = 6'd0;
	localparam logic [KIND_BITS-1:0] K_PLUS       = 6'd1;
	localparam logic [KIND_BITS-1:0] K_MINUS      = 6'd2;
	localparam logic [KIND_BITS-1:0] K_SLASH      = 6'd3;
	localparam logic [KIND_BITS-1:0] K_STAR       = 6'd4;
	localparam logic [KIND_BITS-1:0] K_CARET      = 6'd5;
	localparam logic [KIND_BITS-1:0] K_COMMA      = 6'd6;
	localparam logic [KIND_BITS-1:0] K_LPAREN     = 6'd7;
	localparam logic [KIND_BITS-1:0] K_RPAREN     = 6'd8;
	localparam logic [KIND_BITS-1:0] K_EQUAL      = 6'd9;
	localparam logic [KIND_BITS-1:0] K_INT        = 6'd10;
	localparam logic [KIND_BITS-1:0] K_FLOAT      = 6'd11;
	localparam logic [KIND_BITS-1:0] K_NAME       = 6'd12;
	localparam logic [KIND_BITS-1:0] K_STRING     = 6'd13;
	localparam logic [KIND_BITS-1:0] K_BAD_NUMBER = 6'd14;
	localparam logic [KIND_BITS-1:0] K_BAD_STRING = 6'd15;
	localparam logic [KIND_BITS-1:0] K_BAD_CHAR   = 6'd16;
	localparam logic [KIND_BITS-1:0] K_KEYWORD0   = 6'd17;
	localparam logic [KIND_BITS-1:0] K_LAST_KIND  = 6'd39;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} in_word_t;

	typedef struct packed {
		logic [KIND_BITS-1:0]       token_kind;
		logic [POS_BITS-1:0]        token_start;
		logic [POS_BITS-1:0]        token_length;
		logic signed [VAL_BITS-1:0] int_value;
		logic                       last_of_item;
	} out_word_t;

	// Tokens produced by one accepted word, handed to the output queue.
	typedef struct packed {
		logic [1:0] count;
		out_word_t  tok0;
		out_word_t  tok1;
	} push_t;

	// Keywords in lower case, right-justified.
	localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
		"pi", "e", "t", "ln", "log10", "triangular", "uniform", "normal",
		"negativeexponential", "normalbivariates", "rankcorrelate", "grow",
		"decay", "standarddeviation", "mean", "median", "correlation",
		"rankcorrelation", "percentilebounds", "regression",
		"regressionpercentiles", "valstocsv", "histogramize"
	};
	localparam logic [KW_IDX_BITS-1:0] KW_LEN [KW_COUNT] = '{
		5'd2, 5'd1, 5'd1, 5'd2, 5'd5, 5'd10, 5'd7, 5'd6, 5'd19, 5'd16, 5'd13,
		5'd4, 5'd5, 5'd17, 5'd4, 5'd6, 5'd11, 5'd15, 5'd16, 5'd10, 5'd21,
		5'd9, 5'd12
	};

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
	endfunction

	function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	// Drops every keyword that is too short for index i or whose character at index i differs from c.
	function automatic logic [KW_COUNT-1:0] narrow(input logic [KW_COUNT-1:0] cand,
			input logic [POS_BITS-1:0] i, input logic [7:0] c);
		logic [KW_COUNT-1:0] r;
		logic [KW_IDX_BITS-1:0] idx;
		r = cand;
		for (int k = 0; k < KW_COUNT; k++) begin
			idx = KW_LEN[k] - 1'b1 - i[KW_IDX_BITS-1:0];
			if (i >= POS_BITS'(KW_LEN[k]))
				r[k] = 1'b0;
			else if (KW_TEXT[k][8*idx +: 8] != to_lower(c))
				r[k] = 1'b0;
		end
		return r;
	endfunction

	// First keyword still matching whose length equals the name length.
	function automatic logic [KIND_BITS-1:0] name_kind(input logic [KW_COUNT-1:0] cand,
			input logic [POS_BITS-1:0] len);
		logic [KIND_BITS-1:0] r;
		r = K_NAME;
		for (int k = KW_COUNT - 1; k >= 0; k--)
			if (cand[k] && (len == POS_BITS'(KW_LEN[k])))
				r = K_KEYWORD0 + KIND_BITS'(k);
		return r;
	endfunction

endpackage

// ===== sv/etsc_core.sv =====
// ---------------------------------------------------------------------------
// Expression token scanner core
// Scanner state and the single-pass next-state and token logic.
// ---------------------------------------------------------------------------
module etsc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  etsc_pkg::in_word_t in_word,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data,
	output etsc_pkg::push_t   push
);
	import etsc_pkg::*;

	typedef enum logic [3:0] {
		M_IDLE, M_MINUS, M_INT, M_DOT, M_EXP_START, M_EXP_SIGN, M_EXP_DIGITS,
		M_NAME, M_STRING, M_ERROR
	} mode_t;

	typedef struct packed {
		mode_t                 mode;
		logic [POS_BITS-1:0]   text_pos;
		logic [POS_BITS-1:0]   start_pos;
		logic [POS_BITS-1:0]   len;
		logic [VAL_BITS-1:0]   acc;
		logic                  neg;
		logic                  seen_int;
		logic                  seen_frac;
		logic [KW_COUNT-1:0]   kw;
	} scan_st_t;

	localparam scan_st_t ST_RESET = '{mode: M_IDLE, text_pos: '0, start_pos: '0,
		len: '0, acc: '0, neg: 1'b0, seen_int: 1'b0, seen_frac: 1'b0, kw: '1};
	localparam logic [VAL_BITS-1:0] LIM = VAL_BITS'(1) << (VAL_BITS - 1);

	scan_st_t st_q, nx;
	logic     allow_minus_q;
	out_word_t tok [2];
	logic [1:0] n;
	logic       again;
	logic [7:0] c;
	logic [POS_BITS-1:0] pos;

	function automatic out_word_t mk(input logic [KIND_BITS-1:0] k,
			input logic [POS_BITS-1:0] s, input logic [POS_BITS-1:0] l,
			input logic [VAL_BITS-1:0] v);
		out_word_t t;
		t.token_kind = k;
		t.token_start = s;
		t.token_length = l;
		t.int_value = v;
		t.last_of_item = 1'b0;
		return t;
	endfunction

	// Decimal accumulate with saturation at the magnitude limit.
	function automatic logic [VAL_BITS-1:0] add_digit(input logic [VAL_BITS-1:0] a,
			input logic [7:0] d);
		logic [VAL_BITS+3:0] p;
		p = {a, 3'b000} + {2'b00, a, 1'b0} + (VAL_BITS+4)'(d - "0");
		return (p > (VAL_BITS+4)'(LIM)) ? LIM : p[VAL_BITS-1:0];
	endfunction

	function automatic logic [VAL_BITS-1:0] int_result(input logic [VAL_BITS-1:0] a,
			input logic ng);
		if (ng)
			return '0 - a;
		return (a > LIM - 1'b1) ? LIM - 1'b1 : a;
	endfunction

	// Next state and tokens for the word at the input.
	always_comb begin
		nx = st_q;
		n = 2'd0;
		tok[0] = '0;
		tok[1] = '0;
		again = 1'b0;
		c = in_word.char_code;
		pos = st_q.text_pos;
		if (in_word.end_of_text) begin
			case (st_q.mode)
				M_MINUS: begin
					tok[n[0]] = mk(K_MINUS, st_q.start_pos, POS_BITS'(1), '0); n = n + 2'd1;
				end
				M_INT: begin
					tok[n[0]] = mk(K_INT, st_q.start_pos, st_q.len,
						int_result(st_q.acc, st_q.neg));
					n = n + 2'd1;
				end
				M_DOT: begin
					tok[n[0]] = mk((st_q.seen_int || st_q.seen_frac) ? K_FLOAT : K_BAD_NUMBER,
						st_q.start_pos, st_q.len, '0);
					n = n + 2'd1;
				end
				M_EXP_START, M_EXP_SIGN: begin
					tok[n[0]] = mk(K_BAD_NUMBER, st_q.start_pos, st_q.len, '0); n = n + 2'd1;
				end
				M_EXP_DIGITS: begin
					tok[n[0]] = mk(K_FLOAT, st_q.start_pos, st_q.len, '0); n = n + 2'd1;
				end
				M_NAME: begin
					tok[n[0]] = mk(name_kind(st_q.kw, st_q.len), st_q.start_pos, st_q.len, '0);
					n = n + 2'd1;
				end
				M_STRING: begin
					tok[n[0]] = mk(K_BAD_STRING, st_q.start_pos, st_q.len, '0); n = n + 2'd1;
				end
				default: begin
				end
			endcase
			tok[n[0]] = mk(K_END, st_q.text_pos, '0, '0);
			n = n + 2'd1;
			nx = ST_RESET;
		end else begin
			case (st_q.mode)
				M_MINUS: begin
					if (allow_minus_q && is_digit(c)) begin
						nx.neg = 1'b1; nx.acc = add_digit(st_q.acc, c); nx.seen_int = 1'b1;
						nx.len = sat_inc(st_q.len); nx.mode = M_INT;
					end else if (allow_minus_q && c == ".") begin
						nx.neg = 1'b1; nx.len = sat_inc(st_q.len); nx.mode = M_DOT;
					end else begin
						tok[n[0]] = mk(K_MINUS, st_q.start_pos, POS_BITS'(1), '0);
						n = n + 2'd1; again = 1'b1;
					end
				end
				M_INT: begin
					if (is_digit(c)) begin
						nx.acc = add_digit(st_q.acc, c); nx.len = sat_inc(st_q.len);
					end else if (c == ".") begin
						nx.len = sat_inc(st_q.len); nx.mode = M_DOT;
					end else if (c == "e" || c == "E") begin
						nx.len = sat_inc(st_q.len); nx.mode = M_EXP_START;
					end else begin
						tok[n[0]] = mk(K_INT, st_q.start_pos, st_q.len,
							int_result(st_q.acc, st_q.neg));
						n = n + 2'd1; again = 1'b1;
					end
				end
				M_DOT: begin
					if (is_digit(c)) begin
						nx.seen_frac = 1'b1; nx.len = sat_inc(st_q.len);
					end else if (!st_q.seen_int && !st_q.seen_frac) begin
						tok[n[0]] = mk(K_BAD_NUMBER, st_q.start_pos, sat_inc(st_q.len), '0);
						n = n + 2'd1; nx.mode = M_ERROR;
					end else if (c == "e" || c == "E") begin
						nx.len = sat_inc(st_q.len); nx.mode = M_EXP_START;
					end else begin
						tok[n[0]] = mk(K_FLOAT, st_q.start_pos, st_q.len, '0);
						n = n + 2'd1; again = 1'b1;
					end
				end
				M_EXP_START: begin
					if (c == "+" || c == "-") begin
						nx.len = sat_inc(st_q.len); nx.mode = M_EXP_SIGN;
					end else if (is_digit(c)) begin
						nx.len = sat_inc(st_q.len); nx.mode = M_EXP_DIGITS;
					end else begin
						tok[n[0]] = mk(K_BAD_NUMBER, st_q.start_pos, sat_inc(st_q.len), '0);
						n = n + 2'd1; nx.mode = M_ERROR;
					end
				end
				M_EXP_SIGN: begin
					if (is_digit(c)) begin
						nx.len = sat_inc(st_q.len); nx.mode = M_EXP_DIGITS;
					end else begin
						tok[n[0]] = mk(K_BAD_NUMBER, st_q.start_pos, sat_inc(st_q.len), '0);
						n = n + 2'd1; nx.mode = M_ERROR;
					end
				end
				M_EXP_DIGITS: begin
					if (is_digit(c)) begin
						nx.len = sat_inc(st_q.len);
					end else begin
						tok[n[0]] = mk(K_FLOAT, st_q.start_pos, st_q.len, '0);
						n = n + 2'd1; again = 1'b1;
					end
				end
				M_NAME: begin
					if (is_alpha(c) || is_digit(c) || c == "_") begin
						nx.kw = narrow(st_q.kw, st_q.len, c); nx.len = sat_inc(st_q.len);
					end else begin
						tok[n[0]] = mk(name_kind(st_q.kw, st_q.len), st_q.start_pos, st_q.len, '0);
						n = n + 2'd1; again = 1'b1;
					end
				end
				M_STRING: begin
					if (c == "\"") begin
						tok[n[0]] = mk(K_STRING, st_q.start_pos, st_q.len, '0);
						n = n + 2'd1; nx.mode = M_IDLE;
					end else begin
						nx.len = sat_inc(st_q.len);
					end
				end
				M_ERROR: begin
				end
				default: again = 1'b1;
			endcase

			// The byte was not absorbed: it is skipped if it is white space, else it starts a fresh token.
			if (again) begin
				nx.mode = M_IDLE;
				case (c)
					"+": begin tok[n[0]] = mk(K_PLUS, pos, POS_BITS'(1), '0); n = n + 2'd1; end
					"/": begin tok[n[0]] = mk(K_SLASH, pos, POS_BITS'(1), '0); n = n + 2'd1; end
					"*": begin tok[n[0]] = mk(K_STAR, pos, POS_BITS'(1), '0); n = n + 2'd1; end
					"^": begin tok[n[0]] = mk(K_CARET, pos, POS_BITS'(1), '0); n = n + 2'd1; end
					",": begin tok[n[0]] = mk(K_COMMA, pos, POS_BITS'(1), '0); n = n + 2'd1; end
					"(": begin tok[n[0]] = mk(K_LPAREN, pos, POS_BITS'(1), '0); n = n + 2'd1; end
					")": begin tok[n[0]] = mk(K_RPAREN, pos, POS_BITS'(1), '0); n = n + 2'd1; end
					"=": begin tok[n[0]] = mk(K_EQUAL, pos, POS_BITS'(1), '0); n = n + 2'd1; end
					default: begin
						if (is_space(c)) begin
						end else begin
							nx.start_pos = pos;
							nx.len = POS_BITS'(1);
							nx.acc = '0;
							nx.neg = 1'b0;
							nx.seen_int = 1'b0;
							nx.seen_frac = 1'b0;
							if (c == "-") begin
								nx.mode = M_MINUS;
							end else if (is_digit(c)) begin
								nx.mode = M_INT;
								nx.acc = add_digit('0, c);
								nx.seen_int = 1'b1;
							end else if (c == ".") begin
								nx.mode = M_DOT;
							end else if (is_alpha(c)) begin
								nx.mode = M_NAME;
								nx.kw = narrow('1, '0, c);
							end else if (c == "\"") begin
								nx.mode = M_STRING;
								nx.len = '0;
							end else begin
								tok[n[0]] = mk(K_BAD_CHAR, pos, POS_BITS'(1), '0);
								n = n + 2'd1;
								nx.mode = M_ERROR;
							end
						end
					end
				endcase
			end
			nx.text_pos = sat_inc(pos);
		end

		// Mark the final token of this word.
		if (n == 2'd1)
			tok[0].last_of_item = 1'b1;
		else if (n == 2'd2)
			tok[1].last_of_item = 1'b1;
		push.count = fire ? n : 2'd0;
		push.tok0 = tok[0];
		push.tok1 = tok[1];
	end

	// Scanner state and the configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
			allow_minus_q <= 1'b1;
		end else begin
			if (fire)
				st_q <= nx;
			if (cfg_wr_en)
				allow_minus_q <= cfg_wr_data;
		end
	end

endmodule

// ===== sv/etsc_queue.sv =====
// ---------------------------------------------------------------------------
// Expression token scanner output queue
// Four-entry token queue taking up to two tokens a cycle.
// ---------------------------------------------------------------------------
module etsc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  etsc_pkg::push_t     push,
	output logic                full,
	output logic                out_valid,
	input  logic                out_stall,
	output etsc_pkg::out_word_t out_data
);
	import etsc_pkg::*;

	out_word_t  mem [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       pop;

	// Room for two more tokens is needed before a word is taken.
	assign full = cnt_q > 3'd2;
	assign out_valid = cnt_q != 3'd0;
	assign out_data = mem[rd_q];
	assign pop = out_valid && !out_stall;

	// Token storage.
	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem[wr_q] <= push.tok0;
		if (push.count == 2'd2)
			mem[wr_q + 2'd1] <= push.tok1;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + push.count;
			if (pop)
				rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {1'b0, push.count} - {2'b00, pop};
		end
	end

endmodule

// ===== sv/expression_token_scanner_top.sv =====
// ---------------------------------------------------------------------------
// Expression token scanner
// Turns a byte stream of expression text into tokens.
// ---------------------------------------------------------------------------
// Input words carry one text byte or an end-of-text mark; output words carry
// one token (kind, start, length, integer value, last-of-item flag).
// Both channels use valid and stall; a word moves when valid is high and
// stall is low. The scanner takes one input word per cycle while in_stall is
// low. Tokens are written into a four-entry queue as the byte that ends them
// is taken and are offered from the cycle after, once earlier tokens have left.
// A byte that closes one token and forms another yields two tokens; the queue
// drains one token per cycle while out_stall is low. in_stall rises while
// the queue holds three or more tokens, so a stalled receiver stops input
// once at most three more words have produced tokens. Reset empties the
// queue, returns the scanner to idle at position zero and sets allow_minus_q
// to one. The configuration bit is written through cfg_wr_en and cfg_wr_data.
// ---------------------------------------------------------------------------
module expression_token_scanner_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  etsc_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output etsc_pkg::out_word_t out_data,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data
);
	import etsc_pkg::*;

	push_t push;
	logic  full;
	logic  fire;

	// An input word is taken whenever the queue has room for two tokens.
	assign in_stall = full;
	assign fire = in_valid && !full;

	etsc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.in_word    (in_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.push       (push)
	);

	etsc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

// ===== sv/etsc_checker.sv =====
// ---------------------------------------------------------------------------
// Expression token scanner checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
module etsc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input etsc_pkg::in_word_t  in_data,
	input logic                out_valid,
	input logic                out_stall,
	input etsc_pkg::out_word_t out_data,
	input logic                cfg_wr_en,
	input logic                cfg_wr_data
);
	import etsc_pkg::*;

	// A stalled token stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("token withdrawn while stalled");

	// The end token always closes its word.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.token_kind == K_END |-> out_data.last_of_item)
		else $error("end token not marked last");

	// Only integer tokens carry a value.
	a_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.token_kind != K_INT |-> out_data.int_value == '0)
		else $error("value on non-integer token");

	// After an accepted end-of-text word, a token is offered in the next cycle.
	a_end_flush: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.end_of_text |=> out_valid)
		else $error("no token after end of text");

	// Kinds stay in the defined range.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.token_kind <= K_LAST_KIND)
		else $error("token kind out of range");

	// Unused here but part of the port view.
	logic unused_cfg;
	assign unused_cfg = cfg_wr_en ^ cfg_wr_data;

endmodule

bind expression_token_scanner_top etsc_checker u_etsc_checker (.*);
